[src/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude core
// Register indexes, the front-to-back queue entry and normalization constants.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [11:0] RESET_WIDTH  = 12'd640;
    localparam logic [11:0] RESET_HEIGHT = 12'd480;

    localparam int PIX_W  = 10;   // R+G+B, 0..765
    localparam int GRAD_W = 13;   // signed gradient, -3060..3060
    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;

    // (4328*L)^2 <= 65025*S  ->  K*L^2 <= 65025*S
    localparam int          NORM_DIV = 4328;
    localparam logic [24:0] NORM_K   = 25'(NORM_DIV * NORM_DIV);

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [COL_W-1:0]         column;
        logic [ROW_W-1:0]         row;
        logic                     last;
    } sem_entry_t;

endpackage

[src/sem_front.sv]
// ----------------------------------------------------------------------------
// sem_front: pixel intake, line buffers, 3x3 window and gradient
// Two-stage front: stage 0 accepts and reads the line buffers, stage 1
// forms Gx/Gy and pushes interior pixels into the queue.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    output logic                            push,
    input  logic                            full,
    output sem_pkg::sem_entry_t             entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = sem_pkg::PIX_W;

    logic [11:0]         width_reg;
    logic [11:0]         height_reg;
    logic [CW-1:0]       col_reg;
    logic [11:0]         row_reg;
    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [11:0]         s1_row_reg;
    logic [PW-1:0]       s1_pix_reg;
    logic [2*PW-1:0]     rd_reg;       // {two rows above, one row above}
    logic [PW-1:0]       taps_reg [6];
    logic [2*PW-1:0]     lines [MAX_WIDTH];

    logic [13:0]         width_ext;
    logic [13:0]         eff_width;
    logic [11:0]         eff_height;
    logic [CW-1:0]       last_col;
    logic [11:0]         last_row;
    logic                accept;
    logic                s1_go;
    logic                cfg_hit;
    logic [PW-1:0]       top;
    logic [PW-1:0]       mid;
    logic [11:0]         sum_right;
    logic [11:0]         sum_left;
    logic [11:0]         sum_bottom;
    logic [11:0]         sum_top;
    logic [CW-1:0]       col_m1;

    assign width_ext  = {2'b00, width_reg};
    assign eff_width  = (width_ext < 14'd3) ? 14'd3 :
                        (width_ext > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : width_ext;
    assign eff_height = (height_reg < 12'd3) ? 12'd3 : height_reg;
    assign last_col   = CW'(eff_width - 14'd1);
    assign last_row   = eff_height - 12'd1;

    assign cfg_hit = cfg_write &&
                     (cfg_index == sem_pkg::REG_IMAGE_WIDTH ||
                      cfg_index == sem_pkg::REG_IMAGE_HEIGHT);

    assign s1_go       = s1_valid_reg && (!s1_emit_reg || !full);
    assign pixel_stall = s1_valid_reg && !s1_go;
    assign accept      = pixel_valid && !pixel_stall;
    assign push        = s1_go && s1_emit_reg;

    assign top = rd_reg[2*PW-1:PW];
    assign mid = rd_reg[PW-1:0];

    // Gx: right column minus left column; Gy: bottom row minus top row
    assign sum_right  = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, s1_pix_reg};
    assign sum_left   = {2'b00, taps_reg[0]} + {1'b0, taps_reg[1], 1'b0}
                      + {2'b00, taps_reg[2]};
    assign sum_bottom = {2'b00, taps_reg[2]} + {1'b0, taps_reg[5], 1'b0}
                      + {2'b00, s1_pix_reg};
    assign sum_top    = {2'b00, taps_reg[0]} + {1'b0, taps_reg[3], 1'b0}
                      + {2'b00, top};

    assign col_m1 = s1_col_reg - CW'(1);

    always_comb
    begin
        entry.gx     = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
        entry.gy     = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
        entry.column = sem_pkg::COL_W'(col_m1);
        entry.row    = s1_row_reg - 12'd1;
        entry.last   = s1_last_reg;
    end

    // control state, counters, window taps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= sem_pkg::RESET_WIDTH;
            height_reg   <= sem_pkg::RESET_HEIGHT;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (cfg_hit)
            begin
                if (cfg_index == sem_pkg::REG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg_data;
                end
                else
                begin
                    height_reg <= cfg_data;
                end
                col_reg <= '0;
                row_reg <= '0;
                for (int i = 0; i < 6; i++)
                begin
                    taps_reg[i] <= '0;
                end
            end
            else
            begin
                if (s1_go)
                begin
                    taps_reg[0] <= taps_reg[3];
                    taps_reg[1] <= taps_reg[4];
                    taps_reg[2] <= taps_reg[5];
                    taps_reg[3] <= top;
                    taps_reg[4] <= mid;
                    taps_reg[5] <= s1_pix_reg;
                end
                if (accept)
                begin
                    if (col_reg == last_col)
                    begin
                        col_reg <= '0;
                        row_reg <= (row_reg == last_row) ? 12'd0 : row_reg + 12'd1;
                    end
                    else
                    begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_pix_reg  <= PW'({2'b00, red} + {2'b00, green} + {2'b00, blue});
            s1_emit_reg <= (col_reg >= CW'(2)) && (row_reg >= 12'd2);
            s1_last_reg <= (col_reg == last_col) && (row_reg == last_row);
        end
    end

    // line buffers: read on intake, write back at stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= lines[col_reg];
        end
        if (s1_go)
        begin
            lines[s1_col_reg] <= {mid, s1_pix_reg};
        end
    end

    a_push_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (s1_col_reg <= last_col) && (s1_row_reg <= last_row))
        else $error("pushed item lies outside the frame");

endmodule

[src/sem_queue.sv]
// ----------------------------------------------------------------------------
// sem_queue: small FIFO between the front and the back
// Holds gradient items so intake keeps running while the back iterates.
// ----------------------------------------------------------------------------
module sem_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sem_pkg::sem_entry_t entry_in,
    output logic                full,
    input  logic                pop,
    output sem_pkg::sem_entry_t entry_out,
    output logic                empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    sem_pkg::sem_entry_t slots [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [NW-1:0]       count_reg;

    assign full      = (count_reg == NW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign entry_out = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= entry_in;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

[src/sem_back.sv]
// ----------------------------------------------------------------------------
// sem_back: gradient magnitude normalization
// Squares the gradients, scales by 255^2, then finds the 8-bit level one
// bit at a time (multiply, then compare) and drives the output register.
// ----------------------------------------------------------------------------
module sem_back (
    input  logic                clk,
    input  logic                rst_n,
    output logic                pop,
    input  logic                empty,
    input  sem_pkg::sem_entry_t entry,
    output logic                edge_valid,
    input  logic                edge_stall,
    output logic [7:0]          edge_value,
    output logic [10:0]         center_column,
    output logic [11:0]         center_row,
    output logic                frame_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_TRY,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t       state_reg;
    logic [11:0]  ax_reg;
    logic [11:0]  ay_reg;
    logic [23:0]  sx_reg;
    logic [23:0]  sy_reg;
    logic [40:0]  rhs_reg;
    logic [7:0]   l_reg;
    logic [15:0]  sq_reg;
    logic [16:0]  trial_reg;
    logic [41:0]  prod_reg;
    logic [2:0]   bit_reg;
    logic [10:0]  col_reg;
    logic [11:0]  row_reg;
    logic         last_reg;
    logic         edge_valid_reg;
    logic [7:0]   edge_value_reg;
    logic [10:0]  center_column_reg;
    logic [11:0]  center_row_reg;
    logic         frame_last_reg;

    logic [24:0]  sum_sq;
    logic [40:0]  sum_ext;
    logic [40:0]  rhs_next;
    logic [16:0]  trial_next;
    logic [41:0]  prod_next;
    logic         out_free;

    assign pop = (state_reg == ST_IDLE) && !empty;

    // 65025 = 2^16 - 2^9 + 1
    assign sum_sq   = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign sum_ext  = 41'(sum_sq);
    assign rhs_next = (sum_ext << 16) - (sum_ext << 9) + sum_ext;

    // (L | 2^b)^2 = L^2 + L*2^(b+1) + 2^(2b), L has no bits at or below b
    assign trial_next = 17'(sq_reg) + (17'(l_reg) << ({1'b0, bit_reg} + 4'd1))
                      + (17'(1) << {bit_reg, 1'b0});
    assign prod_next  = {17'b0, sem_pkg::NORM_K} * {25'b0, trial_next};

    assign out_free = !edge_valid_reg || !edge_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_valid_reg <= 1'b0;
        end
        else
        begin
            // in the finish step the output register is reloaded below
            if (edge_valid_reg && !edge_stall && state_reg != ST_FINISH)
            begin
                edge_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        ax_reg    <= entry.gx[12] ? 12'(-entry.gx) : 12'(entry.gx);
                        ay_reg    <= entry.gy[12] ? 12'(-entry.gy) : 12'(entry.gy);
                        col_reg   <= entry.column;
                        row_reg   <= entry.row;
                        last_reg  <= entry.last;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    sx_reg    <= {12'b0, ax_reg} * {12'b0, ax_reg};
                    sy_reg    <= {12'b0, ay_reg} * {12'b0, ay_reg};
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    rhs_reg   <= rhs_next;
                    l_reg     <= '0;
                    sq_reg    <= '0;
                    bit_reg   <= 3'd7;
                    state_reg <= ST_TRY;
                end
                ST_TRY:
                begin
                    trial_reg <= trial_next;
                    prod_reg  <= prod_next;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (prod_reg <= {1'b0, rhs_reg})
                    begin
                        l_reg  <= l_reg | (8'd1 << bit_reg);
                        sq_reg <= trial_reg[15:0];
                    end
                    if (bit_reg == 3'd0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 3'd1;
                        state_reg <= ST_TRY;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        edge_valid_reg    <= 1'b1;
                        edge_value_reg    <= l_reg;
                        center_column_reg <= col_reg;
                        center_row_reg    <= row_reg;
                        frame_last_reg    <= last_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign edge_valid    = edge_valid_reg;
    assign edge_value    = edge_value_reg;
    assign center_column = center_column_reg;
    assign center_row    = center_row_reg;
    assign frame_last    = frame_last_reg;

    a_square_tracks_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRY) |-> (sq_reg == 16'(l_reg) * 16'(l_reg)))
        else $error("running square out of step with level");

endmodule

[src/sobel_edge_magnitude_core.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core: streaming 3x3 Sobel edge magnitude
// RGB raster in, one normalized gradient magnitude per interior pixel out.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  pixel    | pixel_valid / pixel_stall| red, green, blue
//  edge     | edge_valid / edge_stall  | edge_value, center_column, center_row,
//           |                          | frame_last
//  config   | cfg_write                | cfg_index, cfg_data
//
//  Rates: border pixels pass at one per cycle. An interior pixel goes
//  through the normalizer steps (load, square, scale, 8 x try/check, finish),
//  and the back takes the next item only after it; the front keeps taking
//  one pixel per cycle until the queue fills, and the normalizer sets the rate.
//  Reset: counters, window and control clear at once; line buffers are not
//  cleared, only entries written earlier in the frame are ever used.
//  Stalls: edge_stall holds the output register; the back waits in its last
//  step, the queue fills, then pixel_stall rises.
//
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH   = 2048,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel stream
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    // edge stream
    output logic                            edge_valid,
    input  logic                            edge_stall,
    output logic [7:0]                      edge_value,
    output logic [10:0]                     center_column,
    output logic [11:0]                     center_row,
    output logic                            frame_last
);

    // front -> queue -> back
    logic                push;
    logic                full;
    logic                pop;
    logic                empty;
    sem_pkg::sem_entry_t front_entry;
    sem_pkg::sem_entry_t back_entry;

    // intake, line buffers, window, Gx/Gy
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .push        (push),
        .full        (full),
        .entry       (front_entry)
    );

    // decouples one-per-cycle intake, which pixel_stall can hold, from the iterative normalizer
    sem_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (front_entry),
        .full      (full),
        .pop       (pop),
        .entry_out (back_entry),
        .empty     (empty)
    );

    // magnitude normalization and output register
    sem_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop           (pop),
        .empty         (empty),
        .entry         (back_entry),
        .edge_valid    (edge_valid),
        .edge_stall    (edge_stall),
        .edge_value    (edge_value),
        .center_column (center_column),
        .center_row    (center_row),
        .frame_last    (frame_last)
    );

endmodule
